/* rtl/sip_pkg.sv */
// Package for segment_intersection_point: widths and pipeline depths.
// No dependencies.
package sip_pkg;
  localparam int CoordW    = 16;
  localparam int DiffW     = CoordW + 1;        // coordinate differences
  localparam int CrossW    = 2 * DiffW + 1;     // cross products
  localparam int NumW      = CrossW + DiffW;    // n * delta
  localparam int DivBits   = DiffW;             // quotient bits, |q| <= |delta|
  localparam int FrontDepth = 4;
  localparam int DivDepth  = DivBits + 2;       // entry, bit steps, output
  localparam int Depth     = FrontDepth + DivDepth;
endpackage

/* rtl/segment_intersection_point.sv */
// segment_intersection_point: pipelined segment crossing test and point.
// Uses sip_pkg, sip_front, sip_div.
//
// Takes two segments A and B in signed Q8.8 and reports whether they touch
// or cross (bounding boxes overlap and each segment straddles the other's
// line, zero counting as touching). For a crossing with d=(A1-A0)x(B1-B0)
// nonzero, the point is A0 + trunc(n*(A1-A0)/d), n=(B0-A0)x(B1-B0), exact.
// Collinear or degenerate crossings set parallel; without a unique point
// both coordinates are zero. One word is taken per cycle; the pipeline has
// four front stages (differences, 17x17 products, cross products,
// numerators), then a divider with one quotient bit per stage (17) plus
// entry and output stages. The whole pipe advances together and holds
// while the output word waits on m_axis_tready.
module segment_intersection_point
  import sip_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: a_start_x, a_start_y, a_end_x, a_end_y,
  //        b_start_x, b_start_y, b_end_x, b_end_y (16 bits each, low first)
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: point_x [15:0], point_y [31:16]
  output logic [31:0]  m_axis_tdata,
  // tuser: crosses [0], parallel [1]
  output logic [1:0]   m_axis_tuser
);
  logic en;
  logic [Depth-1:0] vld_q;

  // global enable: advance whenever the output word is free or taken
  assign en            = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  logic                     hit, par;
  logic signed [NumW-1:0]   numx, numy;
  logic signed [CrossW-1:0] den;
  logic signed [CoordW-1:0] ax0, ay0;

  sip_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .ax0_i  (s_axis_tdata[15:0]),
    .ay0_i  (s_axis_tdata[31:16]),
    .ax1_i  (s_axis_tdata[47:32]),
    .ay1_i  (s_axis_tdata[63:48]),
    .bx0_i  (s_axis_tdata[79:64]),
    .by0_i  (s_axis_tdata[95:80]),
    .bx1_i  (s_axis_tdata[111:96]),
    .by1_i  (s_axis_tdata[127:112]),
    .hit_o  (hit),
    .par_o  (par),
    .numx_o (numx),
    .numy_o (numy),
    .den_o  (den),
    .ax0_o  (ax0),
    .ay0_o  (ay0)
  );

  logic keep;
  assign keep = hit && !par;

  logic signed [CoordW-1:0] px, py;

  sip_div u_div_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_i   (numx),
    .den_i   (den),
    .base_i  (ax0),
    .keep_i  (keep),
    .point_o (px)
  );

  sip_div u_div_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_i   (numy),
    .den_i   (den),
    .base_i  (ay0),
    .keep_i  (keep),
    .point_o (py)
  );

  // flags ride alongside the divider lanes
  logic [1:0] flag_q [DivDepth];
  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_q[0] <= {par, hit};
      for (int i = 1; i < DivDepth; i++) begin
        flag_q[i] <= flag_q[i-1];
      end
    end
  end

  assign m_axis_tvalid = vld_q[Depth-1];
  assign m_axis_tdata  = {py, px};
  assign m_axis_tuser  = flag_q[DivDepth-1];

`ifndef SYNTH
  a_par_needs_cross : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
    else $error("parallel without crosses");
  a_zero_point : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (!m_axis_tuser[0] || m_axis_tuser[1])) |-> (m_axis_tdata == '0))
    else $error("nonzero point without unique crossing");
  // a stalled output word blocks the input in the same cycle and holds still
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready
      ##1 (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pipe moved during stall");
`endif
endmodule

/* rtl/sip_front.sv */
// Front stages: differences, products, cross products, numerators.
// Uses sip_pkg.
module sip_front
  import sip_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CoordW-1:0] ax0_i, ay0_i, ax1_i, ay1_i,
  input  logic signed [CoordW-1:0] bx0_i, by0_i, bx1_i, by1_i,
  output logic                     hit_o,
  output logic                     par_o,
  output logic signed [NumW-1:0]   numx_o,
  output logic signed [NumW-1:0]   numy_o,
  output logic signed [CrossW-1:0] den_o,
  output logic signed [CoordW-1:0] ax0_o,
  output logic signed [CoordW-1:0] ay0_o
);
  // stage 1: differences and box test
  logic signed [DiffW-1:0] adx_q, ady_q, bdx_q, bdy_q, e0x_q, e0y_q, e1x_q, e1y_q;
  logic signed [DiffW-1:0] f1x_q, f1y_q;
  logic signed [CoordW-1:0] ax0_1q, ay0_1q, ax0_2q, ay0_2q, ax0_3q, ay0_3q;
  logic box_1q, box_2q, box_3q;
  logic signed [CoordW-1:0] amaxx, aminx, amaxy, aminy, bmaxx, bminx, bmaxy, bminy;
  logic box_d;

  always_comb begin
    amaxx = (ax0_i > ax1_i) ? ax0_i : ax1_i;
    aminx = (ax0_i < ax1_i) ? ax0_i : ax1_i;
    amaxy = (ay0_i > ay1_i) ? ay0_i : ay1_i;
    aminy = (ay0_i < ay1_i) ? ay0_i : ay1_i;
    bmaxx = (bx0_i > bx1_i) ? bx0_i : bx1_i;
    bminx = (bx0_i < bx1_i) ? bx0_i : bx1_i;
    bmaxy = (by0_i > by1_i) ? by0_i : by1_i;
    bminy = (by0_i < by1_i) ? by0_i : by1_i;
    box_d = (amaxx >= bminx) && (bmaxx >= aminx) && (amaxy >= bminy) && (bmaxy >= aminy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx_q  <= DiffW'(ax1_i) - DiffW'(ax0_i);
      ady_q  <= DiffW'(ay1_i) - DiffW'(ay0_i);
      bdx_q  <= DiffW'(bx1_i) - DiffW'(bx0_i);
      bdy_q  <= DiffW'(by1_i) - DiffW'(by0_i);
      e0x_q  <= DiffW'(ax0_i) - DiffW'(bx0_i);
      e0y_q  <= DiffW'(ay0_i) - DiffW'(by0_i);
      e1x_q  <= DiffW'(ax1_i) - DiffW'(bx0_i);
      e1y_q  <= DiffW'(ay1_i) - DiffW'(by0_i);
      f1x_q  <= DiffW'(bx1_i) - DiffW'(ax0_i);
      f1y_q  <= DiffW'(by1_i) - DiffW'(ay0_i);
      box_1q <= box_d;
      ax0_1q <= ax0_i;
      ay0_1q <= ay0_i;
    end
  end

  // stage 2: ten 17x17 products
  logic signed [CrossW-1:0] p0a_q, p0b_q, p1a_q, p1b_q, p2a_q, p2b_q;
  logic signed [CrossW-1:0] p3a_q, p3b_q, pda_q, pdb_q;
  logic signed [DiffW-1:0]  adx2_q, ady2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0a_q  <= CrossW'(e0x_q) * CrossW'(bdy_q);
      p0b_q  <= CrossW'(bdx_q) * CrossW'(e0y_q);
      p1a_q  <= CrossW'(e1x_q) * CrossW'(bdy_q);
      p1b_q  <= CrossW'(bdx_q) * CrossW'(e1y_q);
      p2a_q  <= CrossW'(e0x_q) * CrossW'(ady_q);
      p2b_q  <= CrossW'(adx_q) * CrossW'(e0y_q);
      p3a_q  <= CrossW'(f1x_q) * CrossW'(ady_q);
      p3b_q  <= CrossW'(adx_q) * CrossW'(f1y_q);
      pda_q  <= CrossW'(adx_q) * CrossW'(bdy_q);
      pdb_q  <= CrossW'(bdx_q) * CrossW'(ady_q);
      adx2_q <= adx_q;
      ady2_q <= ady_q;
      box_2q <= box_1q;
      ax0_2q <= ax0_1q;
      ay0_2q <= ay0_1q;
    end
  end

  // stage 3: cross products; c2 uses B0-A0 = -(A0-B0), n = -c0
  logic signed [CrossW-1:0] c0_q, c1_q, c2_q, c3_q, d_q;
  logic signed [DiffW-1:0]  adx3_q, ady3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q   <= p0a_q - p0b_q;
      c1_q   <= p1a_q - p1b_q;
      c2_q   <= p2b_q - p2a_q;
      c3_q   <= p3a_q - p3b_q;
      d_q    <= pda_q - pdb_q;
      adx3_q <= adx2_q;
      ady3_q <= ady2_q;
      box_3q <= box_2q;
      ax0_3q <= ax0_2q;
      ay0_3q <= ay0_2q;
    end
  end

  // stage 4: straddle test and numerators
  logic straddle_a, straddle_b, hit_d;
  logic signed [CrossW-1:0] n_d;

  always_comb begin
    straddle_a = !((c0_q > 0 && c1_q > 0) || (c0_q < 0 && c1_q < 0));
    straddle_b = !((c2_q > 0 && c3_q > 0) || (c2_q < 0 && c3_q < 0));
    hit_d      = box_3q && straddle_a && straddle_b;
    n_d        = -c0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o  <= hit_d;
      par_o  <= hit_d && (d_q == '0);
      numx_o <= NumW'(n_d) * NumW'(adx3_q);
      numy_o <= NumW'(n_d) * NumW'(ady3_q);
      den_o  <= d_q;
      ax0_o  <= ax0_3q;
      ay0_o  <= ay0_3q;
    end
  end
endmodule

/* rtl/sip_div.sv */
// Pipelined signed divider lane, one quotient bit per stage, plus offset add.
// Uses sip_pkg.
module sip_div
  import sip_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [NumW-1:0]   num_i,
  input  logic signed [CrossW-1:0] den_i,
  input  logic signed [CoordW-1:0] base_i,
  input  logic                     keep_i,
  output logic signed [CoordW-1:0] point_o
);
  logic [NumW-1:0]    rem_q  [DivBits+1];
  logic [DivBits-1:0] quo_q  [DivBits+1];
  logic [CrossW-1:0]  dmag_q [DivBits+1];
  logic               neg_q  [DivBits+1];
  logic               keep_q [DivBits+1];
  logic [CoordW-1:0]  base_q [DivBits+1];

  // entry: magnitudes and result sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
      dmag_q[0] <= den_i[CrossW-1] ? CrossW'(-den_i) : CrossW'(den_i);
      neg_q[0]  <= num_i[NumW-1] ^ den_i[CrossW-1];
      quo_q[0]  <= '0;
      keep_q[0] <= keep_i;
      base_q[0] <= base_i;
    end
  end

  for (genvar i = 0; i < DivBits; i++) begin : g_step
    localparam int Sh = DivBits - 1 - i;
    logic [NumW:0] trial;
    assign trial = {1'b0, rem_q[i]} - ({(NumW + 1 - CrossW)'(0), dmag_q[i]} << Sh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= trial[NumW] ? rem_q[i] : trial[NumW-1:0];
        quo_q[i+1]  <= quo_q[i] | (DivBits'(!trial[NumW]) << Sh);
        dmag_q[i+1] <= dmag_q[i];
        neg_q[i+1]  <= neg_q[i];
        keep_q[i+1] <= keep_q[i];
        base_q[i+1] <= base_q[i];
      end
    end
  end

  // output: sign fix, add start point, zero when no unique point
  logic [DivBits:0] qs;
  always_comb begin
    qs = neg_q[DivBits] ? -{1'b0, quo_q[DivBits]} : {1'b0, quo_q[DivBits]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      point_o <= keep_q[DivBits] ? CoordW'(base_q[DivBits] + qs[CoordW-1:0]) : '0;
    end
  end
endmodule
